### src/stop_and_wait_frame_receiver_defines.svh
// Assertion macros for the stop-and-wait frame receiver.
// Used by the top level; needs clk and rst_n in scope where expanded.
`ifndef STOP_AND_WAIT_FRAME_RECEIVER_DEFINES_SVH
`define STOP_AND_WAIT_FRAME_RECEIVER_DEFINES_SVH

// Checked only outside reset
`define SFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included
`define SFR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/sfr_pkg.sv
// Shared types and constants for the stop-and-wait frame receiver.
// No dependencies; imported by every module of the block.
package sfr_pkg;

  // Depth of the command queue between parser and reply generator
  localparam int CMD_FIFO_DEPTH = 4;

  // Configuration register indexes
  localparam logic [1:0] CFG_START_MARK = 2'd0;
  localparam logic [1:0] CFG_ACK_CODE   = 2'd1;
  localparam logic [1:0] CFG_NACK_CODE  = 2'd2;
  localparam logic [1:0] CFG_MAX_LENGTH = 2'd3;

  // Configuration reset values
  localparam logic [7:0] RST_START_MARK = 8'd126;
  localparam logic [7:0] RST_ACK_CODE   = 8'd89;
  localparam logic [7:0] RST_NACK_CODE  = 8'd78;
  localparam logic [7:0] RST_MAX_LENGTH = 8'd255;

  // Result kinds
  localparam logic [1:0] OK_PAYLOAD = 2'd0;
  localparam logic [1:0] OK_TX      = 2'd1;
  localparam logic [1:0] OK_STATUS  = 2'd2;

  // Frame status codes
  localparam logic [2:0] ST_ACCEPTED  = 3'd0;
  localparam logic [2:0] ST_PARITY    = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_SEQUENCE  = 3'd3;
  localparam logic [2:0] ST_LENGTH    = 3'd4;

  typedef enum logic [2:0] {
    PH_HUNT, PH_LEN, PH_SEQ, PH_TYPE, PH_DATA, PH_PAR
  } phase_t;

  typedef enum logic [1:0] {
    SC_EXPECTED, SC_PREVIOUS, SC_OTHER
  } seq_class_t;

  // Work handed from parser to reply generator
  typedef enum logic [1:0] {
    CMD_PAYLOAD, CMD_REPLY, CMD_STATUS
  } cmd_kind_t;

  // Position inside a reply burst
  typedef enum logic [2:0] {
    STEP_MARK, STEP_LEN, STEP_SEQ, STEP_CODE, STEP_PARITY, STEP_STATUS
  } reply_step_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;    // payload byte, or reply sequence
    logic [7:0] code;    // ack or nack code
    logic [2:0] status;
    logic [7:0] ftype;
  } cmd_t;

  typedef struct packed {
    logic [7:0] start_mark;
    logic [7:0] ack_code;
    logic [7:0] nack_code;
    logic [7:0] max_length;
  } cfg_t;

endpackage

### src/sfr_frame_parser.sv
// Front end: frame parser, one wire byte per cycle, emits commands.
// Depends on sfr_pkg.
module sfr_frame_parser
  import sfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       byte_valid,
  input  logic [7:0] rx_byte,
  output logic       cmd_push,
  output cmd_t       cmd
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] bytes_left_r, bytes_left_nxt;
  logic [7:0] frame_length_r, frame_length_nxt;
  logic [7:0] frame_seq_r, frame_seq_nxt;
  logic [7:0] frame_kind_r, frame_kind_nxt;
  logic [7:0] parity_r, parity_nxt;
  seq_class_t seq_class_r, seq_class_nxt;
  logic [7:0] exp_seq_r, exp_seq_nxt;

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (byte_valid) begin
      case (phase_r)
        PH_LEN:  phase_nxt = (rx_byte > cfg.max_length) ? PH_HUNT : PH_SEQ;
        PH_SEQ:  phase_nxt = PH_TYPE;
        PH_TYPE: phase_nxt = (frame_length_r == 8'd0) ? PH_PAR : PH_DATA;
        PH_DATA: phase_nxt = (bytes_left_r == 8'd1) ? PH_PAR : PH_DATA;
        PH_PAR:  phase_nxt = PH_HUNT;
        default: phase_nxt = (rx_byte == cfg.start_mark) ? PH_LEN : PH_HUNT;
      endcase
    end
  end

  // Field capture, parity, sequence tracking and command generation
  always_comb begin
    bytes_left_nxt   = bytes_left_r;
    frame_length_nxt = frame_length_r;
    frame_seq_nxt    = frame_seq_r;
    frame_kind_nxt   = frame_kind_r;
    parity_nxt       = parity_r;
    seq_class_nxt    = seq_class_r;
    exp_seq_nxt      = exp_seq_r;
    cmd_push         = 1'b0;
    cmd              = '0;
    if (byte_valid) begin
      case (phase_r)
        PH_LEN: begin
          frame_length_nxt = rx_byte;
          parity_nxt       = rx_byte;
          if (rx_byte > cfg.max_length) begin
            cmd_push   = 1'b1;
            cmd.kind   = CMD_STATUS;
            cmd.status = ST_LENGTH;
          end
        end
        PH_SEQ: begin
          frame_seq_nxt = rx_byte;
          parity_nxt    = parity_r ^ rx_byte;
          if (rx_byte == exp_seq_r) begin
            seq_class_nxt = SC_EXPECTED;
          end else if (rx_byte == exp_seq_r - 8'd1) begin
            seq_class_nxt = SC_PREVIOUS;
          end else begin
            seq_class_nxt = SC_OTHER;
          end
        end
        PH_TYPE: begin
          frame_kind_nxt = rx_byte;
          parity_nxt     = parity_r ^ rx_byte;
          bytes_left_nxt = frame_length_r;
        end
        PH_DATA: begin
          parity_nxt     = parity_r ^ rx_byte;
          bytes_left_nxt = bytes_left_r - 8'd1;
          if (seq_class_r == SC_EXPECTED) begin
            cmd_push = 1'b1;
            cmd.kind = CMD_PAYLOAD;
            cmd.data = rx_byte;
          end
        end
        PH_PAR: begin
          cmd_push  = 1'b1;
          cmd.ftype = frame_kind_r;
          case (seq_class_r)
            SC_EXPECTED: begin
              cmd.kind = CMD_REPLY;
              cmd.data = exp_seq_r;
              if (rx_byte == parity_r) begin
                cmd.code    = cfg.ack_code;
                cmd.status  = ST_ACCEPTED;
                exp_seq_nxt = exp_seq_r + 8'd1;
              end else begin
                cmd.code   = cfg.nack_code;
                cmd.status = ST_PARITY;
              end
            end
            SC_PREVIOUS: begin
              cmd.kind   = CMD_REPLY;
              cmd.data   = frame_seq_r;
              cmd.code   = cfg.ack_code;
              cmd.status = ST_DUPLICATE;
            end
            default: begin
              cmd.kind    = CMD_STATUS;
              cmd.status  = ST_SEQUENCE;
              exp_seq_nxt = 8'd0;
            end
          endcase
        end
        default: begin
          // hunting: nothing captured
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HUNT;
      bytes_left_r   <= '0;
      frame_length_r <= '0;
      frame_seq_r    <= '0;
      frame_kind_r   <= '0;
      parity_r       <= '0;
      seq_class_r    <= SC_EXPECTED;
      exp_seq_r      <= '0;
    end else begin
      phase_r        <= phase_nxt;
      bytes_left_r   <= bytes_left_nxt;
      frame_length_r <= frame_length_nxt;
      frame_seq_r    <= frame_seq_nxt;
      frame_kind_r   <= frame_kind_nxt;
      parity_r       <= parity_nxt;
      seq_class_r    <= seq_class_nxt;
      exp_seq_r      <= exp_seq_nxt;
    end
  end

endmodule

### src/sfr_cmd_fifo.sv
// Command queue between parser and reply generator, flip-flop storage.
// Depends on sfr_pkg.
module sfr_cmd_fifo
  import sfr_pkg::*;
#(
  parameter int DEPTH = CMD_FIFO_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t wdata,
  output logic full,
  input  logic pop,
  output cmd_t rdata,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### src/sfr_reply_gen.sv
// Back end: expands queued commands into result items, one per cycle while
// results are popped, through a one-entry output register. Depends on sfr_pkg.
module sfr_reply_gen
  import sfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] start_mark,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_pop,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic [2:0] out_frame_status,
  output logic [7:0] out_frame_type,
  output logic       out_last
);

  reply_step_t step_r, step_nxt;
  logic        valid_r, valid_nxt;
  logic [1:0]  kind_r;
  logic [7:0]  byte_r;
  logic [2:0]  status_r;
  logic [7:0]  type_r;
  logic        last_r;

  logic [1:0]  res_kind;
  logic [7:0]  res_byte;
  logic [2:0]  res_status;
  logic [7:0]  res_type;
  logic        res_final;
  logic        load;

  // Result for the head command at the current step
  always_comb begin
    res_kind   = OK_TX;
    res_byte   = '0;
    res_status = ST_ACCEPTED;
    res_type   = '0;
    res_final  = 1'b1;
    case (cmd.kind)
      CMD_PAYLOAD: begin
        res_kind = OK_PAYLOAD;
        res_byte = cmd.data;
      end
      CMD_REPLY: begin
        res_final = (step_r == STEP_STATUS);
        case (step_r)
          STEP_MARK:   res_byte = start_mark;
          STEP_LEN:    res_byte = 8'd0;
          STEP_SEQ:    res_byte = cmd.data;
          STEP_CODE:   res_byte = cmd.code;
          STEP_PARITY: res_byte = cmd.data ^ cmd.code;
          default: begin
            res_kind   = OK_STATUS;
            res_status = cmd.status;
            res_type   = cmd.ftype;
          end
        endcase
      end
      default: begin
        res_kind   = OK_STATUS;
        res_status = cmd.status;
        res_type   = cmd.ftype;
      end
    endcase
  end

  // Advance when the output register is free or being emptied
  assign load    = cmd_valid && (!valid_r || pop);
  assign cmd_pop = load && res_final;

  always_comb begin
    step_nxt = step_r;
    if (load) begin
      step_nxt = res_final ? STEP_MARK : reply_step_t'(step_r + 3'd1);
    end
    valid_nxt = load || (valid_r && !pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= STEP_MARK;
      valid_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r   <= res_kind;
      byte_r   <= res_byte;
      status_r <= res_status;
      type_r   <= res_type;
      last_r   <= res_final;
    end
  end

  assign empty            = !valid_r;
  assign out_kind         = kind_r;
  assign out_byte         = byte_r;
  assign out_frame_status = status_r;
  assign out_frame_type   = type_r;
  assign out_last         = last_r;

endmodule

### src/stop_and_wait_frame_receiver.sv
// Stop-and-wait frame receiver top level: config registers, parser,
// command queue, reply generator. Depends on sfr_pkg and the defines header.
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------
//   input    | push / full          | in_rx_byte
//   result   | empty / pop          | out_kind, out_byte, out_frame_status,
//            |                      | out_frame_type, out_last
//   config   | cfg_we               | cfg_index, cfg_wdata
//
// One wire byte is taken per cycle while full is low; the parser handles it in that
// cycle and queues at most one command. The reply generator delivers one result
// per cycle while pop is high: a payload byte or a lone status gives one, a reply
// six (reply frame plus status). full rises only when the command queue is full.
// Reset is synchronous; the block accepts bytes in the first cycle after it.
`include "stop_and_wait_frame_receiver_defines.svh"

module stop_and_wait_frame_receiver
  import sfr_pkg::*;
#(
  parameter int CMD_DEPTH = CMD_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_rx_byte,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic [2:0] out_frame_status,
  output logic [7:0] out_frame_type,
  output logic       out_last
);

  cfg_t cfg_r, cfg_nxt;
  logic byte_valid;
  logic cmd_push;
  cmd_t cmd_in;
  cmd_t cmd_head;
  logic cmd_full;
  logic cmd_empty;
  logic cmd_pop;

  // Configuration write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_START_MARK: cfg_nxt.start_mark = cfg_wdata;
        CFG_ACK_CODE:   cfg_nxt.ack_code   = cfg_wdata;
        CFG_NACK_CODE:  cfg_nxt.nack_code  = cfg_wdata;
        CFG_MAX_LENGTH: cfg_nxt.max_length = cfg_wdata;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_mark <= RST_START_MARK;
      cfg_r.ack_code   <= RST_ACK_CODE;
      cfg_r.nack_code  <= RST_NACK_CODE;
      cfg_r.max_length <= RST_MAX_LENGTH;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign full       = cmd_full;
  assign byte_valid = push && !cmd_full;

  sfr_frame_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .byte_valid (byte_valid),
    .rx_byte    (in_rx_byte),
    .cmd_push   (cmd_push),
    .cmd        (cmd_in)
  );

  sfr_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_head),
    .empty (cmd_empty)
  );

  sfr_reply_gen u_reply_gen (
    .clk              (clk),
    .rst_n            (rst_n),
    .start_mark       (cfg_r.start_mark),
    .cmd_valid        (!cmd_empty),
    .cmd              (cmd_head),
    .cmd_pop          (cmd_pop),
    .empty            (empty),
    .pop              (pop),
    .out_kind         (out_kind),
    .out_byte         (out_byte),
    .out_frame_status (out_frame_status),
    .out_frame_type   (out_frame_type),
    .out_last         (out_last)
  );

  // Checks
  `SFR_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> empty, "result queue not empty after reset")
  `SFR_ASSERT(a_status_last, !empty && out_kind == OK_STATUS |-> out_last, "status without last")
  `SFR_ASSERT(a_kind_legal, !empty |-> out_kind == OK_PAYLOAD || out_kind == OK_TX || out_kind == OK_STATUS, "illegal result kind")
  `SFR_ASSERT(a_nonstatus_clean, !empty && out_kind != OK_STATUS |-> out_frame_status == ST_ACCEPTED && out_frame_type == 8'd0, "non-status result carries status fields")

endmodule
